### rtl/wads_pkg.sv
// shared codes, field widths and score weights of the dispatch scheduler
package wads_pkg;

  // command codes carried on s_tuser
  localparam logic [1:0] CMD_REPORT   = 2'd0;
  localparam logic [1:0] CMD_DISPATCH = 2'd1;
  localparam logic [1:0] CMD_RELEASE  = 2'd2;
  localparam logic [1:0] CMD_TICK     = 2'd3;

  // status codes carried on m_tuser
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_FULL       = 3'd1;
  localparam logic [2:0] ST_NO_PENDING = 3'd2;
  localparam logic [2:0] ST_NO_FREE    = 3'd3;
  localparam logic [2:0] ST_NO_BUSY    = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd5;

  // field widths
  localparam int unsigned SEV_BITS   = 4;
  localparam int unsigned VIC_BITS   = 8;
  localparam int unsigned TICK_BITS  = 32;
  localparam int unsigned RID_BITS   = 7;
  localparam int unsigned UNIT_BITS  = 4;
  localparam int unsigned UCFG_BITS  = 5;
  localparam int unsigned BASE_BITS  = 13;

  // score weights in tenths of a point
  localparam int unsigned SEV_WEIGHT = 50;
  localparam int unsigned VIC_WEIGHT = 20;

  localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

endpackage

### rtl/weighted_aging_dispatch_scheduler_top.sv
// dispatch scheduler: request table, aging score scan and unit allocation
// report, release and tick: result registered in the hand-over state, then moved to the output register
// dispatch: slot scan over the filled part of the table (one registered table read into the shared
//   score unit per cycle), then a probe over the units in use, then the hand-over to the output
// s_tready is high only while idle, so a new item is taken only once the last result is handed over
// reset (rst, synchronous): table empty, all units free, tick counter and unit count at zero
module weighted_aging_dispatch_scheduler_top #(
  parameter int MAX_REQUESTS = 64,
  parameter int MAX_SERVERS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input item
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // command
  input  logic [15:0] s_tdata,   // severity[3:0], victims[11:4], unit_index[15:12]
  // result item
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [2:0]  m_tuser,   // status
  output logic [47:0] m_tdata,   // request_id[6:0], assigned_unit[10:7],
                                 // winning_score[42:11], zero fill above
  // unit count register
  input  logic        cfg_wen,
  input  logic [4:0]  cfg_wdata
);

  // slot index and slot count widths
  localparam int RW  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CW  = $clog2(MAX_REQUESTS + 1);
  // unit index and unit count widths
  localparam int UW  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int UCW = $clog2(MAX_SERVERS + 1);
  localparam int TB  = wads_pkg::TICK_BITS;
  localparam int SB  = wads_pkg::SEV_BITS;
  localparam int VB  = wads_pkg::VIC_BITS;
  localparam int BB  = wads_pkg::BASE_BITS;
  localparam int MW  = SB + VB + TB;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_UNIT = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;

  // request table: severity, victims, arrival tick in one word per slot
  logic [MW-1:0]           req_mem [MAX_REQUESTS];
  logic [MW-1:0]           rd_data;
  logic [MAX_REQUESTS-1:0] req_active;
  logic [CW-1:0]           req_count;

  logic [MAX_SERVERS-1:0]  unit_busy;
  logic [TB-1:0]           now_ticks;
  logic [wads_pkg::UCFG_BITS-1:0] unit_count;

  // scan state
  logic [CW-1:0]  scan_ptr;
  logic           rd_pend;
  logic           rd_act;
  logic [RW-1:0]  rd_slot;
  logic           found;
  logic [RW-1:0]  best;
  logic [TB-1:0]  top_score;
  logic [UCW-1:0] unit_ptr;

  // pending result
  logic [2:0]                    res_status;
  logic [wads_pkg::RID_BITS-1:0] res_rid;
  logic [wads_pkg::UNIT_BITS-1:0] res_unit;
  logic [TB-1:0]                 res_score;

  // input fields
  logic [1:0]    in_cmd;
  logic [SB-1:0] in_sev;
  logic [VB-1:0] in_vic;
  logic [3:0]    in_uidx;
  logic          in_fire;

  assign in_cmd  = s_tuser;
  assign in_sev  = s_tdata[3:0];
  assign in_vic  = s_tdata[11:4];
  assign in_uidx = s_tdata[15:12];
  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;

  // units in use: the register clamped to the pool size
  logic [UCW-1:0]         n_units;
  logic [MAX_SERVERS-1:0] use_mask;
  logic                   any_busy;
  logic [UW+3:0]          rel_wide;
  logic [UW-1:0]          rel_idx;
  logic                   rel_out;

  always_comb begin
    if (32'(unit_count) > 32'(MAX_SERVERS)) begin
      n_units = UCW'(MAX_SERVERS);
    end else begin
      n_units = UCW'(unit_count);
    end
    for (int i = 0; i < MAX_SERVERS; i++) begin
      use_mask[i] = (i < int'(n_units));
    end
  end

  assign any_busy = |(unit_busy & use_mask);
  assign rel_wide = {{UW{1'b0}}, in_uidx};
  assign rel_idx  = rel_wide[UW-1:0];
  assign rel_out  = (8'(in_uidx) >= 8'(n_units));

  // table read issue during the slot scan
  logic          issue;
  logic [RW-1:0] rd_addr;
  logic          do_report;

  assign issue     = (state == S_SCAN) && (scan_ptr < req_count);
  assign rd_addr   = scan_ptr[RW-1:0];
  assign do_report = in_fire && (in_cmd == wads_pkg::CMD_REPORT) &&
                     (32'(req_count) < 32'(MAX_REQUESTS));

  always_ff @(posedge clk) begin
    if (do_report) begin
      req_mem[req_count[RW-1:0]] <= {in_sev, in_vic, now_ticks};
    end
    if (issue) begin
      rd_data <= req_mem[rd_addr];
    end
  end

  // shared score unit: weighted base plus age, saturated, against the best so far
  logic [SB-1:0] rd_sev;
  logic [VB-1:0] rd_vic;
  logic [TB-1:0] rd_arrival;
  logic [BB-1:0] base;
  logic [TB:0]   score_sum;
  logic [TB-1:0] score;
  logic          better;

  assign rd_sev     = rd_data[MW-1 -: SB];
  assign rd_vic     = rd_data[TB +: VB];
  assign rd_arrival = rd_data[TB-1:0];
  assign base       = BB'(rd_sev) * BB'(wads_pkg::SEV_WEIGHT) +
                      BB'(rd_vic) * BB'(wads_pkg::VIC_WEIGHT);
  assign score_sum  = {1'b0, now_ticks - rd_arrival} + (TB + 1)'(base);
  assign score      = score_sum[TB] ? wads_pkg::TICK_MAX : score_sum[TB-1:0];
  assign better     = rd_act && (!found || (score > top_score));

  // free unit probe
  logic [UW-1:0] unit_sel;
  logic          unit_end;
  logic          grant;

  assign unit_sel = unit_ptr[UW-1:0];
  assign unit_end = (unit_ptr >= n_units);
  assign grant    = (state == S_UNIT) && !unit_end && !unit_busy[unit_sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      req_active <= '0;
      req_count  <= '0;
      unit_busy  <= '0;
      now_ticks  <= '0;
      unit_count <= '0;
      scan_ptr   <= '0;
      rd_pend    <= 1'b0;
      rd_act     <= 1'b0;
      rd_slot    <= '0;
      found      <= 1'b0;
      best       <= '0;
      top_score  <= '0;
      unit_ptr   <= '0;
      res_status <= wads_pkg::ST_OK;
      res_rid    <= '0;
      res_unit   <= '0;
      res_score  <= '0;
      m_tvalid   <= 1'b0;
      m_tuser    <= wads_pkg::ST_OK;
      m_tdata    <= '0;
    end else begin
      if (cfg_wen) begin
        unit_count <= cfg_wdata;
      end
      // the hand-over state sets valid itself
      if (m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            res_status <= wads_pkg::ST_OK;
            res_rid    <= '0;
            res_unit   <= '0;
            res_score  <= '0;
            state      <= S_DONE;
            case (in_cmd)
              wads_pkg::CMD_REPORT: begin
                if (do_report) begin
                  req_active[req_count[RW-1:0]] <= 1'b1;
                  req_count <= req_count + CW'(1);
                  res_rid   <= wads_pkg::RID_BITS'(req_count + CW'(1));
                end else begin
                  res_status <= wads_pkg::ST_FULL;
                end
              end
              wads_pkg::CMD_DISPATCH: begin
                scan_ptr <= '0;
                rd_pend  <= 1'b0;
                found    <= 1'b0;
                state    <= S_SCAN;
              end
              wads_pkg::CMD_RELEASE: begin
                if (!any_busy) begin
                  res_status <= wads_pkg::ST_NO_BUSY;
                end else if (rel_out) begin
                  res_status <= wads_pkg::ST_NOT_FOUND;
                end else begin
                  unit_busy[rel_idx] <= 1'b0;
                end
              end
              default: begin
                // time tick, held at the top value
                if (now_ticks != wads_pkg::TICK_MAX) begin
                  now_ticks <= now_ticks + TB'(1);
                end
              end
            endcase
          end
        end

        S_SCAN: begin
          // read for the next slot goes out while the previous one is scored
          rd_pend <= issue;
          if (issue) begin
            scan_ptr <= scan_ptr + CW'(1);
            rd_slot  <= rd_addr;
            rd_act   <= req_active[rd_addr];
          end
          if (rd_pend && better) begin
            found     <= 1'b1;
            best      <= rd_slot;
            top_score <= score;
          end
          if (!issue && !rd_pend) begin
            if (found) begin
              unit_ptr <= '0;
              state    <= S_UNIT;
            end else begin
              res_status <= wads_pkg::ST_NO_PENDING;
              state      <= S_DONE;
            end
          end
        end

        S_UNIT: begin
          if (unit_end) begin
            res_status <= wads_pkg::ST_NO_FREE;
            state      <= S_DONE;
          end else if (grant) begin
            unit_busy[unit_sel] <= 1'b1;
            req_active[best]    <= 1'b0;
            res_rid   <= wads_pkg::RID_BITS'({1'b0, best} + (RW + 1)'(1));
            res_unit  <= wads_pkg::UNIT_BITS'(unit_ptr);
            res_score <= top_score;
            state     <= S_DONE;
          end else begin
            unit_ptr <= unit_ptr + UCW'(1);
          end
        end

        S_DONE: begin
          // hand over once the output register is free or being emptied
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {5'b0, res_score, res_unit, res_rid};
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // scan never runs past the filled part of the table
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_ptr <= req_count))
    else $error("slot scan beyond table fill");

  // the unit probe is only entered with a winner in hand
  a_unit_has_best: assert property (@(posedge clk) disable iff (rst)
    (state == S_UNIT) |-> found)
    else $error("unit probe without a pending winner");

  // a grant makes the unit busy and retires the request
  a_grant_effect: assert property (@(posedge clk) disable iff (rst)
    grant |=> (unit_busy[$past(unit_sel)] && !req_active[$past(best)]))
    else $error("grant did not take effect");

  // an accepted report into a table with room adds exactly one slot
  a_report_count: assert property (@(posedge clk) disable iff (rst)
    do_report |=> (req_count == $past(req_count) + CW'(1)))
    else $error("report did not advance the slot count");

endmodule

### tb/tb_weighted_aging_dispatch_scheduler_top.sv
// self-checking testbench for the weighted aging dispatch scheduler: directed table, random phases
module tb_weighted_aging_dispatch_scheduler_top;
  timeunit 1ns;
  timeprecision 1ps;

  // table and pool sizes of the instance under test, and the score weights in tenths
  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned UNIT_POOL   = 16;
  localparam int unsigned W_SEVERITY  = 50;
  localparam int unsigned W_VICTIMS   = 20;

  localparam int unsigned ITEMS_PER_PHASE = 60;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned DRAIN_CYCLES    = 100;  // a full-table dispatch plus the unit scan
  localparam int unsigned MAX_PRINTS      = 100;

  // one result item as it leaves the block
  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  rid;
    logic [3:0]  unit;
    logic [31:0] score;
  } outcome_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  // a row either writes the unit count or sends one item; typed rows carry their result
  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  cmd;
    logic [3:0]  sev;
    logic [7:0]  vic;
    logic [3:0]  uidx;
    logic [4:0]  ucnt;
    bit          typed;
    logic [2:0]  status;
    logic [6:0]  rid;
    logic [3:0]  unit;
    logic [31:0] score;
  } script_row_t;

  localparam int unsigned SCRIPT_LEN = 26;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid;
  logic        s_tready;
  logic [1:0]  s_tuser;
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [2:0]  m_tuser;
  logic [47:0] m_tdata;
  logic        cfg_wen;
  logic [4:0]  cfg_wdata;

  // mirror of the scheduler state; bit types start at zero, which is the reset state
  bit [3:0]    tbl_sev [TABLE_DEPTH];
  bit [7:0]    tbl_vic [TABLE_DEPTH];
  bit [31:0]   tbl_arr [TABLE_DEPTH];
  bit          tbl_live [TABLE_DEPTH];
  int unsigned tbl_fill;
  bit          unit_taken [UNIT_POOL];
  bit [31:0]   clock_ticks;
  bit [4:0]    units_cfg;

  outcome_t    pending_outcomes [$];
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned settings_used;
  int unsigned status_tally [6];
  bit          tx_idle;
  bit          rx_idle;

  logic [4:0]  phase_units [NUM_PHASES] = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd5, 5'd17, 5'd0, 5'd16};

  // directed rows: unit count starts at zero after reset
  script_row_t script [SCRIPT_LEN] = '{
    // no units at all: empty table, nothing busy, then a request with nowhere to go
    '{ROW_ITEM, wads_pkg::CMD_DISPATCH, 0, 0, 0, 0, 1, wads_pkg::ST_NO_PENDING, 0, 0, 0},
    '{ROW_ITEM, wads_pkg::CMD_RELEASE, 0, 0, 0, 0, 1, wads_pkg::ST_NO_BUSY, 0, 0, 0},
    '{ROW_ITEM, wads_pkg::CMD_TICK, 0, 0, 0, 0, 1, wads_pkg::ST_OK, 0, 0, 0},
    '{ROW_ITEM, wads_pkg::CMD_REPORT, 15, 255, 0, 0, 1, wads_pkg::ST_OK, 1, 0, 0},
    '{ROW_ITEM, wads_pkg::CMD_DISPATCH, 0, 0, 0, 0, 1, wads_pkg::ST_NO_FREE, 0, 0, 0},
    // count above the pool size behaves as the full pool
    '{ROW_CFG, wads_pkg::CMD_REPORT, 0, 0, 0, 31, 0, wads_pkg::ST_OK, 0, 0, 0},
    '{ROW_ITEM, wads_pkg::CMD_RELEASE, 0, 0, 15, 0, 1, wads_pkg::ST_NO_BUSY, 0, 0, 0},
    '{ROW_ITEM, wads_pkg::CMD_REPORT, 0, 0, 0, 0, 1, wads_pkg::ST_OK, 2, 0, 0},
    '{ROW_ITEM, wads_pkg::CMD_REPORT, 15, 255, 0, 0, 1, wads_pkg::ST_OK, 3, 0, 0},
    '{ROW_ITEM, wads_pkg::CMD_TICK, 0, 0, 0, 0, 1, wads_pkg::ST_OK, 0, 0, 0},
    // equal top scores: the earlier slot goes first
    '{ROW_ITEM, wads_pkg::CMD_DISPATCH, 0, 0, 0, 0, 1, wads_pkg::ST_OK, 1, 0, 5851},
    '{ROW_ITEM, wads_pkg::CMD_DISPATCH, 0, 0, 0, 0, 1, wads_pkg::ST_OK, 3, 1, 5851},
    // freeing a unit that is already free still reports ok
    '{ROW_ITEM, wads_pkg::CMD_RELEASE, 0, 0, 15, 0, 1, wads_pkg::ST_OK, 0, 0, 0},
    '{ROW_ITEM, wads_pkg::CMD_RELEASE, 0, 0, 0, 0, 1, wads_pkg::ST_OK, 0, 0, 0},
    '{ROW_ITEM, wads_pkg::CMD_DISPATCH, 0, 0, 0, 0, 1, wads_pkg::ST_OK, 2, 0, 1},
    // one unit in use: unit 1 stays busy but out of reach
    '{ROW_CFG, wads_pkg::CMD_REPORT, 0, 0, 0, 1, 0, wads_pkg::ST_OK, 0, 0, 0},
    '{ROW_ITEM, wads_pkg::CMD_RELEASE, 0, 0, 1, 0, 1, wads_pkg::ST_NOT_FOUND, 0, 0, 0},
    '{ROW_ITEM, wads_pkg::CMD_REPORT, 7, 128, 0, 0, 0, wads_pkg::ST_OK, 0, 0, 0},
    '{ROW_ITEM, wads_pkg::CMD_DISPATCH, 0, 0, 0, 0, 0, wads_pkg::ST_OK, 0, 0, 0},
    '{ROW_ITEM, wads_pkg::CMD_RELEASE, 0, 0, 0, 0, 0, wads_pkg::ST_OK, 0, 0, 0},
    '{ROW_ITEM, wads_pkg::CMD_DISPATCH, 0, 0, 0, 0, 0, wads_pkg::ST_OK, 0, 0, 0},
    // back to the full pool: unit 1 kept its request while hidden
    '{ROW_CFG, wads_pkg::CMD_REPORT, 0, 0, 0, 16, 0, wads_pkg::ST_OK, 0, 0, 0},
    '{ROW_ITEM, wads_pkg::CMD_RELEASE, 0, 0, 1, 0, 0, wads_pkg::ST_OK, 0, 0, 0},
    '{ROW_ITEM, wads_pkg::CMD_REPORT, 8, 1, 0, 0, 0, wads_pkg::ST_OK, 0, 0, 0},
    '{ROW_ITEM, wads_pkg::CMD_TICK, 0, 0, 0, 0, 0, wads_pkg::ST_OK, 0, 0, 0},
    '{ROW_ITEM, wads_pkg::CMD_DISPATCH, 0, 0, 0, 0, 0, wads_pkg::ST_OK, 0, 0, 0}
  };

  weighted_aging_dispatch_scheduler_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // works out the result of one item and moves the mirrored state on
  function automatic outcome_t predict_outcome(input logic [1:0] cmd, input logic [15:0] data);
    outcome_t    r;
    int unsigned n;
    int unsigned i;
    int unsigned best;
    int unsigned open_unit;
    logic [63:0] wide;
    logic [31:0] sc;
    logic [31:0] best_sc;
    bit          found;
    bit          got;
    bit          any;
    logic [3:0]  idx;
    r = '0;
    n = (units_cfg > UNIT_POOL) ? UNIT_POOL : units_cfg;
    best = 0;
    best_sc = '0;
    found = 1'b0;
    got = 1'b0;
    any = 1'b0;
    open_unit = 0;
    idx = data[15:12];
    case (cmd)
      wads_pkg::CMD_REPORT: begin
        if (tbl_fill >= TABLE_DEPTH) begin
          r.status = wads_pkg::ST_FULL;
        end else begin
          tbl_sev[tbl_fill] = data[3:0];
          tbl_vic[tbl_fill] = data[11:4];
          tbl_arr[tbl_fill] = clock_ticks;
          tbl_live[tbl_fill] = 1'b1;
          tbl_fill++;
          r.rid = 7'(tbl_fill);
        end
      end
      wads_pkg::CMD_DISPATCH: begin
        for (i = 0; i < tbl_fill; i++) begin
          if (tbl_live[i]) begin
            // aging term is the tick distance since arrival, sum saturates at 32 bits
            wide = 64'(tbl_sev[i]) * W_SEVERITY + 64'(tbl_vic[i]) * W_VICTIMS
                 + 64'(clock_ticks - tbl_arr[i]);
            sc = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
            if (!found || sc > best_sc) begin
              found = 1'b1;
              best = i;
              best_sc = sc;
            end
          end
        end
        for (i = 0; i < n; i++) begin
          if (!got && !unit_taken[i]) begin
            got = 1'b1;
            open_unit = i;
          end
        end
        if (!found) begin
          r.status = wads_pkg::ST_NO_PENDING;
        end else if (!got) begin
          r.status = wads_pkg::ST_NO_FREE;
        end else begin
          unit_taken[open_unit] = 1'b1;
          tbl_live[best] = 1'b0;
          r.rid = 7'(best + 1);
          r.unit = 4'(open_unit);
          r.score = best_sc;
        end
      end
      wads_pkg::CMD_RELEASE: begin
        for (i = 0; i < n; i++)
          if (unit_taken[i]) any = 1'b1;
        if (!any) begin
          r.status = wads_pkg::ST_NO_BUSY;
        end else if (idx >= n) begin
          r.status = wads_pkg::ST_NOT_FOUND;
        end else begin
          unit_taken[idx] = 1'b0;
        end
      end
      default: begin
        if (clock_ticks != 32'hFFFF_FFFF) clock_ticks++;
      end
    endcase
    status_tally[r.status]++;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    if (fail_count <= MAX_PRINTS)
      $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
  endtask

  // offers one item and waits for it to be taken; valid stays up when the next follows at once
  task automatic send_item(input logic [1:0] cmd, input logic [15:0] data, input bit typed,
                           input outcome_t want, input bit last);
    outcome_t    predicted;
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    predicted = predict_outcome(cmd, data);
    pending_outcomes.push_back(typed ? want : predicted);
    items_sent++;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (last || gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // register write only once every result has come back, so the block is idle
  task automatic write_unit_count(input logic [4:0] value);
    while (pending_outcomes.size() != 0) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    units_cfg = value;
    settings_used++;
  endtask

  // result side: takes results with random stalls and checks them in order
  initial begin
    outcome_t    want;
    int unsigned stall;
    m_tready = 1'b0;
    while (rst) @(posedge clk);
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (pending_outcomes.size() == 0) begin
          report_mismatch("result with nothing expected, status", 32'(m_tuser), 32'd0);
        end else begin
          want = pending_outcomes.pop_front();
          if (m_tuser !== want.status)
            report_mismatch("status", 32'(m_tuser), 32'(want.status));
          if (m_tdata[6:0] !== want.rid)
            report_mismatch("request id", 32'(m_tdata[6:0]), 32'(want.rid));
          if (m_tdata[10:7] !== want.unit)
            report_mismatch("assigned unit", 32'(m_tdata[10:7]), 32'(want.unit));
          if (m_tdata[42:11] !== want.score)
            report_mismatch("winning score", m_tdata[42:11], want.score);
          if (m_tdata[47:43] !== 5'd0)
            report_mismatch("zero fill", 32'(m_tdata[47:43]), 32'd0);
        end
        stall = rx_idle ? $urandom_range(0, 9) : 0;
        if (stall != 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
          m_tready <= 1'b1;
        end
      end
    end
  end

  // stimulus: directed table first, then random phases under different unit counts
  initial begin
    outcome_t    want;
    logic [15:0] data;
    logic [1:0]  cmd;
    logic [4:0]  ucnt;
    int unsigned n_in_use;
    int unsigned pick;
    bit          last;
    s_tvalid  = 1'b0;
    s_tuser   = wads_pkg::CMD_REPORT;
    s_tdata   = '0;
    cfg_wen   = 1'b0;
    cfg_wdata = '0;
    tx_idle   = 1'b1;
    rx_idle   = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < SCRIPT_LEN; k++) begin
      if (script[k].kind == ROW_CFG) begin
        write_unit_count(script[k].ucnt);
      end else begin
        last = (k + 1 == SCRIPT_LEN) ? 1'b1 : (script[k + 1].kind == ROW_CFG);
        want = {script[k].status, script[k].rid, script[k].unit, script[k].score};
        send_item(script[k].cmd, {script[k].uidx, script[k].vic, script[k].sev},
                  script[k].typed, want, last);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      // idling pattern rotates: both sides, neither side, result side only
      tx_idle = (p % 3 == 0);
      rx_idle = (p % 3 != 1);
      ucnt = (p == 6) ? 5'($urandom_range(0, 31)) : phase_units[p];
      write_unit_count(ucnt);
      n_in_use = (ucnt > UNIT_POOL) ? UNIT_POOL : ucnt;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        pick = $urandom_range(0, 99);
        // reports are kept sparse so the table lasts through most of the run
        if (pick < 18)       cmd = wads_pkg::CMD_REPORT;
        else if (pick < 50)  cmd = wads_pkg::CMD_DISPATCH;
        else if (pick < 76)  cmd = wads_pkg::CMD_RELEASE;
        else                 cmd = wads_pkg::CMD_TICK;
        data = 16'($urandom);
        // most items are shaped; the rest keep fully random fields as noise
        if ($urandom_range(0, 99) >= 12) begin
          // small weights make score ties between requests likely
          if (cmd == wads_pkg::CMD_REPORT && $urandom_range(0, 1) == 1) begin
            data[3:0]  = 4'($urandom_range(0, 2));
            data[11:4] = 8'($urandom_range(0, 3));
          end
          if (cmd == wads_pkg::CMD_RELEASE && n_in_use != 0)
            data[15:12] = 4'($urandom_range(0, n_in_use - 1));
        end
        send_item(cmd, data, 1'b0, '0, i == ITEMS_PER_PHASE - 1);
      end
    end

    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d items and %0d results across %0d unit-count settings",
             items_sent, results_seen, settings_used);
    $display("status mix: ok %0d, full %0d, no pending %0d, no free %0d, no busy %0d, %s %0d",
             status_tally[wads_pkg::ST_OK], status_tally[wads_pkg::ST_FULL],
             status_tally[wads_pkg::ST_NO_PENDING], status_tally[wads_pkg::ST_NO_FREE],
             status_tally[wads_pkg::ST_NO_BUSY], "not found",
             status_tally[wads_pkg::ST_NOT_FOUND]);
    if (fail_count == 0) begin
      $display("tb_weighted_aging_dispatch_scheduler_top OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("tb_weighted_aging_dispatch_scheduler_top NOT OK");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("timeout with %0d results still expected", pending_outcomes.size());
    $display("tb_weighted_aging_dispatch_scheduler_top NOT OK");
    $finish;
  end

endmodule

### files.f
rtl/wads_pkg.sv
rtl/weighted_aging_dispatch_scheduler_top.sv
tb/tb_weighted_aging_dispatch_scheduler_top.sv
